### hw/rtl/urc_pkg.sv
// shared types, constants and codes for the ultrasonic ranging controller
package urc_pkg;

  // field widths
  localparam int TIME_W  = 16;
  localparam int REG_W   = 16;
  localparam int WIDTH_W = 17;
  localparam int DIST_W  = 32;
  localparam int IDX_W   = 2;

  // timer stamp width, limited to the capture field
  localparam int STAMP_BITS = 16;
  localparam int STAMP_W    = (STAMP_BITS < TIME_W) ? STAMP_BITS : TIME_W;

  // fixed-point scaling of the distance product
  localparam int DIST_SHIFT = 10;
  localparam int PROD_W     = WIDTH_W + REG_W;

  // register reset values
  localparam logic [REG_W-1:0] CYCLE_PERIOD_RST  = 16'd60;
  localparam logic [REG_W-1:0] ECHO_TIMEOUT_RST  = 16'd40;
  localparam logic [REG_W-1:0] DISTANCE_SCALE_RST = 16'd4496;

  // elapsed millisecond counter saturation
  localparam logic [REG_W-1:0] MS_MAX = '1;

  // register indexes
  localparam logic [IDX_W-1:0] REG_CYCLE_PERIOD   = 2'd0;
  localparam logic [IDX_W-1:0] REG_ECHO_TIMEOUT   = 2'd1;
  localparam logic [IDX_W-1:0] REG_DISTANCE_SCALE = 2'd2;

  // input function codes
  localparam logic FUNC_TICK    = 1'b0;
  localparam logic FUNC_CAPTURE = 1'b1;

  // echo level codes
  localparam logic LEVEL_FALL = 1'b0;
  localparam logic LEVEL_RISE = 1'b1;

  // sequencer phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'b01,
    PH_ECHO = 2'b10
  } phase_t;

  // sequencer status for one step
  typedef struct packed {
    logic trigger;
    logic waiting;
  } seq_stat_t;

endpackage

### hw/rtl/urc_if.sv
// valid/ready channel interfaces for input items and result items
interface urc_in_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [urc_pkg::TIME_W-1:0]   capture_time;
  logic                         echo_level;

  modport source (output valid, func, capture_time, echo_level, input ready);
  modport sink (input valid, func, capture_time, echo_level, output ready);
endinterface

interface urc_out_if;
  logic                         valid;
  logic                         ready;
  logic                         trigger_request;
  logic                         waiting_echo;
  logic                         new_measure;
  logic [urc_pkg::WIDTH_W-1:0]  echo_width_us;
  logic [urc_pkg::DIST_W-1:0]   distance_q8;

  modport source (output valid, trigger_request, waiting_echo, new_measure, echo_width_us,
                  distance_q8, input ready);
  modport sink (input valid, trigger_request, waiting_echo, new_measure, echo_width_us,
                distance_q8, output ready);
endinterface

### hw/rtl/urc_seq.sv
// two-phase millisecond sequencer: idle period, trigger request, echo wait
module urc_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       tick,
  input  logic [urc_pkg::REG_W-1:0]  cycle_period_ms,
  input  logic [urc_pkg::REG_W-1:0]  echo_timeout_ms,
  output urc_pkg::seq_stat_t         stat
);
  import urc_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [REG_W-1:0]  elapsed_r, elapsed_nxt;
  logic [REG_W-1:0]  elapsed_inc;
  logic [REG_W-1:0]  limit;
  logic              trig;

  // saturating count, then compare with the limit of the current phase
  always_comb begin
    elapsed_inc = (elapsed_r == MS_MAX) ? elapsed_r : elapsed_r + 1'b1;
    limit       = (phase_r == PH_IDLE) ? cycle_period_ms : echo_timeout_ms;
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    trig        = 1'b0;
    if (tick) begin
      elapsed_nxt = elapsed_inc;
      if (elapsed_inc >= limit) begin
        elapsed_nxt = '0;
        case (phase_r)
          PH_IDLE: begin
            phase_nxt = PH_ECHO;
            trig      = 1'b1;
          end
          PH_ECHO: begin
            phase_nxt = PH_IDLE;
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      elapsed_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  assign stat.trigger = trig;
  assign stat.waiting = (phase_nxt == PH_ECHO);

endmodule

### hw/rtl/urc_meas.sv
// echo pulse width from edge stamps and scaled distance
module urc_meas (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cap_rise,
  input  logic                         cap_fall,
  input  logic [urc_pkg::TIME_W-1:0]   capture_time,
  input  logic [urc_pkg::REG_W-1:0]    distance_scale,
  output logic [urc_pkg::WIDTH_W-1:0]  width_now,
  output logic [urc_pkg::DIST_W-1:0]   distance_now
);
  import urc_pkg::*;

  logic [STAMP_W-1:0]  rise_r;
  logic [WIDTH_W-1:0]  width_r, width_nxt;
  logic [STAMP_W-1:0]  stamp;
  logic [STAMP_W:0]    span;
  logic [PROD_W-1:0]   product;

  // width with wrap: a fall not after the rise gains one full timer period
  always_comb begin
    stamp     = capture_time[STAMP_W-1:0];
    span      = {(stamp <= rise_r), stamp} - {1'b0, rise_r};
    width_nxt = cap_fall ? WIDTH_W'(span) : width_r;
    product   = PROD_W'(width_nxt) * PROD_W'(distance_scale);
  end

  // stamp and width registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_r  <= '0;
      width_r <= '0;
    end else begin
      if (cap_rise) begin
        rise_r <= stamp;
      end
      width_r <= width_nxt;
    end
  end

  assign width_now    = width_nxt;
  assign distance_now = DIST_W'(product[PROD_W-1:DIST_SHIFT]);

endmodule

### hw/rtl/ultrasonic_ranging_controller.sv
// top level of the ultrasonic ranging controller
//
//   port     dir   kind          contents
//   in_ch    in    valid/ready   func, capture_time, echo_level
//   out_ch   out   valid/ready   trigger_request, waiting_echo, new_measure,
//                                echo_width_us, distance_q8
//   cfg_*    in    write only    cycle_period_ms, echo_timeout_ms, distance_scale
//
// one beat in, one beat out; the result shows in the cycle after acceptance
// and a new beat is taken every cycle while the output register drains
// in_ch.ready is low only while a result sits in the output register unclaimed
// synchronous active-low reset restores the default registers and idle phase
// the sequencer update and the 17x16 distance multiply share the accept cycle
module ultrasonic_ranging_controller (
  input  logic                        clk,
  input  logic                        rst_n,
  urc_in_if.sink                      in_ch,
  urc_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [urc_pkg::IDX_W-1:0]   cfg_index,
  input  logic [urc_pkg::REG_W-1:0]   cfg_wdata
);
  import urc_pkg::*;

  logic [REG_W-1:0]    cycle_period_r;
  logic [REG_W-1:0]    echo_timeout_r;
  logic [REG_W-1:0]    distance_scale_r;
  logic                accept;
  logic                tick;
  logic                cap_rise;
  logic                cap_fall;
  seq_stat_t           stat;
  logic [WIDTH_W-1:0]  width_now;
  logic [DIST_W-1:0]   distance_now;

  logic                out_valid_r;
  logic                trigger_r;
  logic                waiting_r;
  logic                fresh_r;
  logic [WIDTH_W-1:0]  width_r;
  logic [DIST_W-1:0]   distance_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycle_period_r   <= CYCLE_PERIOD_RST;
      echo_timeout_r   <= ECHO_TIMEOUT_RST;
      distance_scale_r <= DISTANCE_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CYCLE_PERIOD:   cycle_period_r   <= cfg_wdata;
        REG_ECHO_TIMEOUT:   echo_timeout_r   <= cfg_wdata;
        REG_DISTANCE_SCALE: distance_scale_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // beat decode
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign tick        = accept && (in_ch.func == FUNC_TICK);
  assign cap_rise    = accept && (in_ch.func == FUNC_CAPTURE) && (in_ch.echo_level == LEVEL_RISE);
  assign cap_fall    = accept && (in_ch.func == FUNC_CAPTURE) && (in_ch.echo_level == LEVEL_FALL);

  urc_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .tick            (tick),
    .cycle_period_ms (cycle_period_r),
    .echo_timeout_ms (echo_timeout_r),
    .stat            (stat)
  );

  urc_meas u_meas (
    .clk            (clk),
    .rst_n          (rst_n),
    .cap_rise       (cap_rise),
    .cap_fall       (cap_fall),
    .capture_time   (in_ch.capture_time),
    .distance_scale (distance_scale_r),
    .width_now      (width_now),
    .distance_now   (distance_now)
  );

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_r <= accept;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      trigger_r  <= stat.trigger;
      waiting_r  <= stat.waiting;
      fresh_r    <= cap_fall;
      width_r    <= width_now;
      distance_r <= distance_now;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.trigger_request = trigger_r;
  assign out_ch.waiting_echo    = waiting_r;
  assign out_ch.new_measure     = fresh_r;
  assign out_ch.echo_width_us   = width_r;
  assign out_ch.distance_q8     = distance_r;

endmodule
